// File: hw/rtl/dqe_pkg.sv
// Package for the double-ended queue: sizes, request and status codes,
// cell commands and the request, result and slot structs.
// No dependencies.
`default_nettype none

package dqe_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned CountW = $clog2(DEPTH + 1);
  localparam int unsigned DataW  = 32;

  typedef enum logic [2:0] {
    REQ_READ       = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_PUSH_BACK  = 3'd3,
    REQ_POP_BACK   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_ROTATE
  } cell_cmd_e;

  typedef enum logic [0:0] {
    FSM_IDLE,
    FSM_READ
  } fsm_e;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [DataW-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] data_value;
    logic [1:0]              status;
    logic                    last_result;
  } res_t;

  // one queue position: occupied flag and stored value
  typedef struct packed {
    logic                    occ;
    logic signed [DataW-1:0] data;
  } slot_t;

endpackage

`default_nettype wire

// File: hw/rtl/dqe_cell.sv
// One position of the queue row. Shifts with its neighbors on push/pop
// at the front, fills or drains at the tail, rotates during a read-out.
// Depends on dqe_pkg.
`default_nettype none

module dqe_cell (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire dqe_pkg::cell_cmd_e               cmd_i,
  input  wire logic signed [dqe_pkg::DataW-1:0] push_value_i,
  input  wire dqe_pkg::slot_t                   left_i,
  input  wire dqe_pkg::slot_t                   right_i,
  input  wire logic signed [dqe_pkg::DataW-1:0] head_data_i,
  output dqe_pkg::slot_t                        slot_o
);

  logic                             occ_q, occ_d;
  logic signed [dqe_pkg::DataW-1:0] data_q, data_d;
  logic                             is_tail;

  assign is_tail = occ_q & ~right_i.occ;

  always_comb begin
    occ_d  = occ_q;
    data_d = data_q;
    case (cmd_i)
      dqe_pkg::CMD_PUSH_FRONT: begin
        occ_d  = left_i.occ;
        data_d = left_i.data;
      end
      dqe_pkg::CMD_PUSH_BACK: begin
        // first free slot behind the tail
        if (!occ_q && left_i.occ) begin
          occ_d  = 1'b1;
          data_d = push_value_i;
        end
      end
      dqe_pkg::CMD_POP_FRONT: begin
        occ_d  = right_i.occ;
        data_d = right_i.data;
      end
      dqe_pkg::CMD_POP_BACK: begin
        if (is_tail) begin
          occ_d = 1'b0;
        end
      end
      dqe_pkg::CMD_ROTATE: begin
        // occupied part rotates one place toward the head
        if (occ_q) begin
          data_d = is_tail ? head_data_i : right_i.data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign slot_o.occ  = occ_q;
  assign slot_o.data = data_q;

endmodule

`default_nettype wire

// File: hw/rtl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values, built as a row of
// cells with the front always in cell 0. Depends on dqe_pkg, dqe_cell.
//
// Requests enter on in_valid_i / in_stall_o / in_req_i; results leave on
// out_valid_o / out_stall_i / out_res_o; a transfer is an edge with valid
// high and stall low.
// Push and pop at either end give one registered result in the cycle
// after the request is taken; with no result stall, one request per cycle.
// Push to a full queue reports overflow, pop from an empty one underflow;
// the queue is untouched. Unknown request codes are taken and dropped.
// Read-all: one result per element, front to back, last one flagged; an
// empty queue gives one result with the empty status in the next cycle.
// Otherwise the occupied cells rotate one place per cycle while the
// output is free and cell 0 is sent; the request passes through the state
// register, then the output register, the input stays stalled for the
// whole read-out, and the cells end in their original order.
// A stalled result holds in the output register; new requests and the
// read-out wait until it is taken. Reset empties the queue and drops any
// pending result; stored values are not cleared.
`default_nettype none

module double_ended_queue (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_stall_o,
  input  wire dqe_pkg::req_t in_req_i,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output dqe_pkg::res_t out_res_o
);

  localparam int unsigned Depth  = dqe_pkg::DEPTH;
  localparam int unsigned CountW = dqe_pkg::CountW;

  dqe_pkg::slot_t     slots [Depth];
  dqe_pkg::cell_cmd_e cmd;

  dqe_pkg::fsm_e     state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic              out_valid_q;
  dqe_pkg::res_t     res_q, res_d;
  logic              out_load;
  logic              out_free;
  logic              in_acc;
  logic              q_empty, q_full;
  logic signed [dqe_pkg::DataW-1:0] tail_data;

  // ---- cell row ----
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    dqe_pkg::slot_t left_s, right_s;

    if (i == 0) begin : g_first
      assign left_s.occ  = 1'b1;
      assign left_s.data = in_req_i.push_value;
    end else begin : g_mid_l
      assign left_s = slots[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_s.occ  = 1'b0;
      assign right_s.data = '0;
    end else begin : g_mid_r
      assign right_s = slots[i+1];
    end

    dqe_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .push_value_i (in_req_i.push_value),
      .left_i       (left_s),
      .right_i      (right_s),
      .head_data_i  (slots[0].data),
      .slot_o       (slots[i])
    );
  end

  assign q_empty = ~slots[0].occ;
  assign q_full  = slots[Depth-1].occ;

  // one-hot select of the tail cell for pop back
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < Depth; i++) begin
      if (slots[i].occ && (i == Depth - 1 || !slots[(i + 1) % Depth].occ)) begin
        tail_data = tail_data | slots[i].data;
      end
    end
  end

  // ---- handshake ----
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != dqe_pkg::FSM_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---- control ----
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rem_d    = rem_q;
    cmd      = dqe_pkg::CMD_HOLD;
    out_load = 1'b0;
    res_d    = res_q;
    case (state_q)
      dqe_pkg::FSM_IDLE: begin
        if (in_acc) begin
          res_d.data_value  = '0;
          res_d.last_result = 1'b1;
          res_d.status      = dqe_pkg::ST_OK;
          case (dqe_pkg::req_e'(in_req_i.req_type))
            dqe_pkg::REQ_READ: begin
              if (q_empty) begin
                out_load     = 1'b1;
                res_d.status = dqe_pkg::ST_EMPTY;
              end else begin
                state_d = dqe_pkg::FSM_READ;
                rem_d   = count_q;
              end
            end
            dqe_pkg::REQ_PUSH_FRONT, dqe_pkg::REQ_PUSH_BACK: begin
              out_load = 1'b1;
              if (q_full) begin
                res_d.status = dqe_pkg::ST_OVERFLOW;
              end else begin
                cmd     = (in_req_i.req_type == dqe_pkg::REQ_PUSH_FRONT)
                          ? dqe_pkg::CMD_PUSH_FRONT : dqe_pkg::CMD_PUSH_BACK;
                count_d = count_q + CountW'(1);
              end
            end
            dqe_pkg::REQ_POP_FRONT, dqe_pkg::REQ_POP_BACK: begin
              out_load = 1'b1;
              if (q_empty) begin
                res_d.status = dqe_pkg::ST_UNDERFLOW;
              end else if (in_req_i.req_type == dqe_pkg::REQ_POP_FRONT) begin
                cmd              = dqe_pkg::CMD_POP_FRONT;
                count_d          = count_q - CountW'(1);
                res_d.data_value = slots[0].data;
              end else begin
                cmd              = dqe_pkg::CMD_POP_BACK;
                count_d          = count_q - CountW'(1);
                res_d.data_value = tail_data;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dqe_pkg::FSM_READ: begin
        if (out_free) begin
          out_load          = 1'b1;
          res_d.data_value  = slots[0].data;
          res_d.status      = dqe_pkg::ST_OK;
          res_d.last_result = (rem_q == CountW'(1));
          cmd               = dqe_pkg::CMD_ROTATE;
          rem_d             = rem_q - CountW'(1);
          if (rem_q == CountW'(1)) begin
            state_d = dqe_pkg::FSM_IDLE;
          end
        end
      end
      default: begin
        state_d = dqe_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dqe_pkg::FSM_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

`ifndef SYNTHESIS
  // element count and the cell occupancy flags must agree at both ends
  a_empty_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == q_empty)
    else $error("count and head occupancy disagree");

  a_full_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CountW'(Depth)) == q_full)
    else $error("count and tail occupancy disagree");

  a_read_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dqe_pkg::FSM_READ) |-> (rem_q != '0 && rem_q <= count_q))
    else $error("read-out remainder out of range");

  a_read_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dqe_pkg::FSM_READ) |-> in_stall_o)
    else $error("request taken during read-out");

  a_count_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dqe_pkg::FSM_READ) |=> $stable(count_q))
    else $error("count changed during read-out");
`endif

endmodule

`default_nettype wire
